FILE: rtl/tas_pkg.sv
`default_nettype none
package tas_pkg;

   // Problem size and fixed-point formats.
   localparam int CITIES     = 20;
   localparam int COORD_BITS = 8;
   localparam int CIDX_W     = $clog2(CITIES);
   localparam int SCORE_W    = 16;
   localparam int TEMP_W     = 52;
   localparam int NLR_W      = 20;
   localparam int LN2_Q16    = 45426;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_START = 2'd1,
      KIND_SWAP  = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // Register indexes of the write port.
   localparam logic [1:0] CSR_INIT_TEMP = 2'd0;
   localparam logic [1:0] CSR_COOLING   = 2'd1;
   localparam logic [1:0] CSR_STOP      = 2'd2;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  city_index;
      logic [7:0]  x_coord;
      logic [7:0]  y_coord;
      logic [4:0]  swap_first;
      logic [4:0]  swap_second;
      logic [15:0] random_draw;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [15:0] current_score;
      logic [15:0] candidate_score;
      logic        finished;
      logic [4:0]  city_at_position;
      logic        bad_request;
   } rsp_type;

   typedef logic [15:0] ln_tab_type [64];

   // Shift-and-subtract division, used only while building the table below.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] rem;
      q   = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], n[b]};
         if (rem >= d) begin
            rem  = rem - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // ln(1 + i/64) in Q16, from the atanh series in Q30.
   function automatic ln_tab_type build_ln_table();
      ln_tab_type  tab;
      logic [63:0] y;
      logic [63:0] y2;
      logic [63:0] p;
      logic [63:0] sum;
      for (int i = 0; i < 64; i++) begin
         y   = udiv64(64'(i) << 30, 64'(128 + i));
         y2  = (y * y) >> 30;
         p   = y;
         sum = '0;
         for (int k = 1; k <= 25; k += 2) begin
            sum = sum + udiv64(p, 64'(k));
            p   = (p * y2) >> 30;
         end
         tab[i] = 16'((64'd2 * sum + 64'd8192) >> 14);
      end
      return tab;
   endfunction

   localparam ln_tab_type LN_TABLE = build_ln_table();

endpackage
`default_nettype wire

FILE: rtl/tour_annealing_step.sv
`default_nettype none
// One request at a time; the tour walk reads one position per cycle through the tour
// memory and the city memory, then a swap's multiply steps form the threshold and cooling.
// Reset (synchronous, active high): tour is identity order, score and temperature zero,
// the run counts as finished, registers take their default values. City memory is unset.
module tour_annealing_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tas_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tas_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import tas_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_WALK, ST_WALK_END, ST_LOG, ST_MUL_LO, ST_MUL_HI,
      ST_DECIDE, ST_COOL_LO, ST_COOL_HI, ST_COOL_SUM, ST_WR_A, ST_WR_B, ST_RESP
   } state_type;

   localparam int CW = COORD_BITS;

   state_type           state_ff;
   req_type             req_ff;
   logic [19:0]         init_temp_ff;
   logic [31:0]         cool_ff;
   logic [31:0]         stop_ff;
   logic [CITIES-1:0]   valid_ff;
   logic [SCORE_W-1:0]  score_ff;
   logic [TEMP_W-1:0]   temp_ff;
   logic                done_ff;
   logic [CIDX_W:0]     cnt_ff;
   logic                s1_ff, s2_ff;
   logic [CIDX_W-1:0]   p1_ff, p2_ff;
   logic                swap_en_ff;
   logic [CIDX_W-1:0]   sa_ff, sb_ff;
   logic [CIDX_W-1:0]   val_sa_ff, val_sb_ff;
   logic [CW-1:0]       prev_x_ff, prev_y_ff;
   logic [SCORE_W-1:0]  total_ff;
   logic [NLR_W-1:0]    nlr_ff;
   logic [37:0]         prod_a_ff, prod_b_ff;
   logic [31:0]         cprod_lo_ff;
   logic [TEMP_W-1:0]   cprod_hi_ff;
   logic                acc_ff, bad_ff;
   logic [SCORE_W-1:0]  cand_ff;
   logic [4:0]          pos_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   // Tour memory with its read register.
   logic [CIDX_W-1:0]   tour_mem [CITIES];
   logic [CIDX_W-1:0]   t_rdata_ff, t_raddr_ff;
   logic                t_rvalid_ff;
   logic                t_ren, t_wen;
   logic [CIDX_W-1:0]   t_raddr, t_waddr, t_wdata, t_city;

   // City coordinate memory, x in the upper half.
   logic [2*CW-1:0]     city_mem [CITIES];
   logic [2*CW-1:0]     c_rdata_ff;
   logic                c_wen;

   logic                accept;
   logic                walk_issue;
   logic [CIDX_W-1:0]   walk_pos;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign walk_issue = (state_ff == ST_WALK) && (int'(cnt_ff) < CITIES);
   assign walk_pos   = cnt_ff[CIDX_W-1:0];

   function automatic logic in_range(input logic [4:0] v);
      return int'(v) < CITIES;
   endfunction

   // Tour read address: a read request, or the next position of the walk with the
   // proposed swap applied on the fly.
   always_comb begin
      t_ren   = 1'b0;
      t_raddr = walk_pos;
      if (state_ff == ST_IDLE && accept && req_data.kind == KIND_READ &&
          in_range(req_data.city_index)) begin
         t_ren   = 1'b1;
         t_raddr = CIDX_W'(req_data.city_index);
      end else if (walk_issue) begin
         t_ren = 1'b1;
         if (swap_en_ff && walk_pos == sa_ff) begin
            t_raddr = sb_ff;
         end else if (swap_en_ff && walk_pos == sb_ff) begin
            t_raddr = sa_ff;
         end
      end
   end

   // Tour writes commit an accepted swap, one position per cycle.
   assign t_wen   = (state_ff == ST_WR_A) || (state_ff == ST_WR_B);
   assign t_waddr = (state_ff == ST_WR_A) ? sa_ff : sb_ff;
   assign t_wdata = (state_ff == ST_WR_A) ? val_sa_ff : val_sb_ff;

   // An entry not written since the last start holds its own position.
   assign t_city = t_rvalid_ff ? t_rdata_ff : t_raddr_ff;

   always_ff @(posedge clock) begin
      if (t_wen) begin
         tour_mem[t_waddr] <= t_wdata;
      end
      if (t_ren) begin
         t_rdata_ff <= tour_mem[t_raddr];
      end
   end

   assign c_wen = (state_ff == ST_IDLE) && accept && req_data.kind == KIND_LOAD &&
                  in_range(req_data.city_index);

   always_ff @(posedge clock) begin
      if (c_wen) begin
         city_mem[CIDX_W'(req_data.city_index)] <=
            {CW'(req_data.x_coord), CW'(req_data.y_coord)};
      end
      if (s1_ff) begin
         c_rdata_ff <= city_mem[t_city];
      end
   end

   // Edge length and running sum, saturated.
   logic [CW-1:0]      cx, cy, dx, dy;
   logic [SCORE_W:0]   sum_wide;
   logic [SCORE_W-1:0] walk_total;

   always_comb begin
      cx = c_rdata_ff[2*CW-1:CW];
      cy = c_rdata_ff[CW-1:0];
      dx = (cx > prev_x_ff) ? cx - prev_x_ff : prev_x_ff - cx;
      dy = (cy > prev_y_ff) ? cy - prev_y_ff : prev_y_ff - cy;
      sum_wide = {1'b0, total_ff} + (SCORE_W+1)'(dx) + (SCORE_W+1)'(dy);
      walk_total = sum_wide[SCORE_W] ? '1 : sum_wide[SCORE_W-1:0];
   end

   // -ln r in Q4.16 from a leading-zero count and the table.
   logic [4:0]       lz;
   logic             found;
   logic [15:0]      mant;
   logic [NLR_W-1:0] nlr;

   always_comb begin
      lz    = '0;
      found = 1'b0;
      for (int b = 15; b >= 0; b--) begin
         if (!found) begin
            if (req_ff.random_draw[b]) begin
               found = 1'b1;
            end else begin
               lz = lz + 5'd1;
            end
         end
      end
      mant = req_ff.random_draw << lz;
      nlr  = NLR_W'(lz + 5'd1) * NLR_W'(LN2_Q16) - NLR_W'(LN_TABLE[mant[14:9]]);
   end

   // Acceptance test and cooling arithmetic.
   logic [SCORE_W-1:0] delta;
   logic [55:0]        thresh;
   logic               take;
   logic [TEMP_W-1:0]  temp_next;
   logic [TEMP_W-1:0]  temp_start;

   always_comb begin
      delta      = total_ff - score_ff;
      thresh     = {prod_b_ff, 18'b0} + 56'(prod_a_ff);
      take       = (total_ff <= score_ff) || (req_ff.random_draw == '0) ||
                   (56'({delta, 32'b0}) < thresh);
      temp_next  = cprod_hi_ff + TEMP_W'(cprod_lo_ff);
      temp_start = {init_temp_ff, 32'b0};
   end

   // Sequencer, state and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_temp_ff <= 20'd1000000;
         cool_ff      <= 32'd4294924346;
         stop_ff      <= 32'd4294967;
         valid_ff     <= '0;
         score_ff     <= '0;
         temp_ff      <= '0;
         done_ff      <= 1'b1;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_INIT_TEMP: init_temp_ff <= csr_wdata[19:0];
               CSR_COOLING:   cool_ff      <= csr_wdata;
               CSR_STOP:      stop_ff      <= csr_wdata;
               default: ;
            endcase
         end

         // The result register is refilled in the response state, so it is
         // only emptied here in the other states.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_RESP) begin
            rsp_valid_ff <= 1'b0;
         end

         // Walk pipeline: tour read, then city read, then accumulate.
         s1_ff <= walk_issue;
         s2_ff <= s1_ff;
         p1_ff <= walk_pos;
         p2_ff <= p1_ff;
         if (t_ren) begin
            t_raddr_ff  <= t_raddr;
            t_rvalid_ff <= valid_ff[t_raddr];
         end
         if (walk_issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (s1_ff) begin
            if (p1_ff == sa_ff) val_sa_ff <= t_city;
            if (p1_ff == sb_ff) val_sb_ff <= t_city;
         end
         if (s2_ff) begin
            prev_x_ff <= cx;
            prev_y_ff <= cy;
            total_ff  <= (p2_ff == '0) ? '0 : walk_total;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff  <= req_data;
                  acc_ff  <= 1'b0;
                  cand_ff <= '0;
                  pos_ff  <= '0;
                  bad_ff  <= 1'b0;
                  cnt_ff  <= '0;
                  case (req_data.kind)
                     KIND_LOAD: begin
                        bad_ff   <= !in_range(req_data.city_index);
                        state_ff <= ST_RESP;
                     end
                     KIND_START: begin
                        valid_ff   <= '0;
                        swap_en_ff <= 1'b0;
                        sa_ff      <= '0;
                        sb_ff      <= '0;
                        state_ff   <= ST_WALK;
                     end
                     KIND_SWAP: begin
                        sa_ff      <= CIDX_W'(req_data.swap_first);
                        sb_ff      <= CIDX_W'(req_data.swap_second);
                        swap_en_ff <= 1'b1;
                        if (!in_range(req_data.swap_first) ||
                            !in_range(req_data.swap_second) ||
                            req_data.swap_first == req_data.swap_second) begin
                           bad_ff   <= 1'b1;
                           state_ff <= ST_RESP;
                        end else if (done_ff) begin
                           state_ff <= ST_RESP;
                        end else begin
                           state_ff <= ST_WALK;
                        end
                     end
                     default: begin
                        if (in_range(req_data.city_index)) begin
                           state_ff <= ST_READ;
                        end else begin
                           bad_ff   <= 1'b1;
                           state_ff <= ST_RESP;
                        end
                     end
                  endcase
               end
            end
            ST_READ: begin
               pos_ff   <= 5'(t_city);
               state_ff <= ST_RESP;
            end
            ST_WALK: begin
               if (s2_ff && p2_ff == CIDX_W'(CITIES - 1)) begin
                  state_ff <= ST_WALK_END;
               end
            end
            ST_WALK_END: begin
               if (swap_en_ff) begin
                  cand_ff  <= total_ff;
                  state_ff <= ST_LOG;
               end else begin
                  score_ff <= total_ff;
                  temp_ff  <= temp_start;
                  done_ff  <= temp_start <= TEMP_W'(stop_ff);
                  state_ff <= ST_RESP;
               end
            end
            ST_LOG: begin
               nlr_ff   <= nlr;
               state_ff <= ST_MUL_LO;
            end
            ST_MUL_LO: begin
               prod_a_ff <= 38'(temp_ff[33:16]) * 38'(nlr_ff);
               state_ff  <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               prod_b_ff <= 38'(temp_ff[51:34]) * 38'(nlr_ff);
               state_ff  <= ST_DECIDE;
            end
            ST_DECIDE: begin
               acc_ff <= take;
               if (take) begin
                  score_ff <= total_ff;
               end
               state_ff <= ST_COOL_LO;
            end
            ST_COOL_LO: begin
               cprod_lo_ff <= 32'((64'(temp_ff[31:0]) * 64'(cool_ff)) >> 32);
               state_ff    <= ST_COOL_HI;
            end
            ST_COOL_HI: begin
               cprod_hi_ff <= TEMP_W'(temp_ff[51:32]) * TEMP_W'(cool_ff);
               state_ff    <= ST_COOL_SUM;
            end
            ST_COOL_SUM: begin
               temp_ff <= temp_next;
               if (temp_next <= TEMP_W'(stop_ff)) begin
                  done_ff <= 1'b1;
               end
               state_ff <= acc_ff ? ST_WR_A : ST_RESP;
            end
            ST_WR_A: begin
               valid_ff[sa_ff] <= 1'b1;
               state_ff        <= ST_WR_B;
            end
            ST_WR_B: begin
               valid_ff[sb_ff] <= 1'b1;
               state_ff        <= ST_RESP;
            end
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff                 <= 1'b1;
                  rsp_data_ff.accepted         <= acc_ff;
                  rsp_data_ff.current_score    <= score_ff;
                  rsp_data_ff.candidate_score  <= cand_ff;
                  rsp_data_ff.finished         <= done_ff;
                  rsp_data_ff.city_at_position <= pos_ff;
                  rsp_data_ff.bad_request      <= bad_ff;
                  state_ff                     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: rtl/tas_checker.sv
`default_nettype none
module tas_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire tas_pkg::rsp_type rsp_data
);
   import tas_pkg::*;

   // A result that waits is held unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A kept swap makes its candidate the current score.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.accepted |-> rsp_data.current_score == rsp_data.candidate_score)
      else $error("kept swap did not update score");

   // A faulty request is never kept.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_request |-> !rsp_data.accepted)
      else $error("bad request reported as accepted");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result present after reset");

   // An accepted request is not answered in the cycle after it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind tour_annealing_step tas_checker u_tas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: verif/tb_tour_annealing_step.sv
`default_nettype none
module tb_tour_annealing_step;
   import tas_pkg::*;

   typedef logic [4:0] order_type [CITIES];

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   // Shadow copy of the block's state and registers.
   order_type       tour_now;
   logic [7:0]      city_xs [CITIES];
   logic [7:0]      city_ys [CITIES];
   logic [15:0]     score_held;
   longint unsigned temp_held;
   bit              run_over;
   logic [19:0]     start_temp;
   logic [31:0]     cool_mult;
   logic [31:0]     stop_temp;
   logic [15:0]     log_tab [64];

   rsp_type pending_rsps [$];
   int      error_count;
   int      idle_pct;
   int      stall_pct;

   tour_annealing_step DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 2000000);
      $display("Test completed with failures");
      $finish;
   end

   // ln(1 + i/64) in Q16 via the atanh series, worked in Q30.
   function automatic void fill_log_tab();
      longint unsigned y;
      longint unsigned y2;
      longint unsigned p;
      longint unsigned acc;
      for (int i = 0; i < 64; i++) begin
         y   = (longint'(i) << 30) / (128 + i);
         y2  = (y * y) >> 30;
         p   = y;
         acc = 0;
         for (int k = 1; k <= 25; k += 2) begin
            acc = acc + p / k;
            p   = (p * y2) >> 30;
         end
         log_tab[i] = 16'((2 * acc + 8192) >> 14);
      end
   endfunction

   // Open-path Manhattan length of a tour, saturating at the score width.
   function automatic logic [15:0] tour_length(input order_type ord);
      int total;
      int a;
      int b;
      int dx;
      int dy;
      total = 0;
      for (int i = 0; i + 1 < CITIES; i++) begin
         a  = ord[i];
         b  = ord[i + 1];
         dx = city_xs[a] > city_xs[b] ? city_xs[a] - city_xs[b] : city_xs[b] - city_xs[a];
         dy = city_ys[a] > city_ys[b] ? city_ys[a] - city_ys[b] : city_ys[b] - city_ys[a];
         total = total + dx + dy;
         if (total > 65535) total = 65535;
      end
      return 16'(total);
   endfunction

   // -ln r in Q4.16 from a leading-zero count and the table; r is non-zero.
   function automatic longint unsigned neg_log(input logic [15:0] r);
      logic [15:0] m;
      int          lz;
      m  = r;
      lz = 0;
      while (!m[15]) begin
         m  = m << 1;
         lz = lz + 1;
      end
      return longint'(lz + 1) * LN2_Q16 - log_tab[m[14:9]];
   endfunction

   // Advance the shadow state by one request and give the expected response.
   function automatic rsp_type anneal_predict(input req_type q);
      rsp_type         o;
      order_type       trial;
      logic [4:0]      t;
      longint unsigned delta;
      longint unsigned lim;
      o = '0;
      case (q.kind)
         KIND_LOAD: begin
            if (q.city_index < CITIES) begin
               city_xs[q.city_index] = q.x_coord;
               city_ys[q.city_index] = q.y_coord;
            end else begin
               o.bad_request = 1'b1;
            end
         end
         KIND_START: begin
            for (int i = 0; i < CITIES; i++) tour_now[i] = 5'(i);
            score_held = tour_length(tour_now);
            temp_held  = longint'(start_temp) << 32;
            run_over   = temp_held <= stop_temp;
         end
         KIND_SWAP: begin
            if (q.swap_first >= CITIES || q.swap_second >= CITIES ||
                q.swap_first == q.swap_second) begin
               o.bad_request = 1'b1;
            end else if (!run_over) begin
               trial = tour_now;
               t = trial[q.swap_first];
               trial[q.swap_first]  = trial[q.swap_second];
               trial[q.swap_second] = t;
               o.candidate_score = tour_length(trial);
               if (o.candidate_score <= score_held || q.random_draw == 0) begin
                  o.accepted = 1'b1;
               end else begin
                  delta = o.candidate_score - score_held;
                  lim   = (temp_held >> 16) * neg_log(q.random_draw);
                  if ((delta << 32) < lim) o.accepted = 1'b1;
               end
               if (o.accepted) begin
                  tour_now   = trial;
                  score_held = o.candidate_score;
               end
               temp_held = (temp_held >> 32) * cool_mult +
                           (((temp_held & 64'hFFFF_FFFF) * cool_mult) >> 32);
               if (temp_held <= stop_temp) run_over = 1'b1;
            end
         end
         default: begin
            if (q.city_index < CITIES) o.city_at_position = tour_now[q.city_index];
            else o.bad_request = 1'b1;
         end
      endcase
      o.current_score = score_held;
      o.finished      = run_over;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Send one request, holding it until accepted, then record its expected response.
   task automatic send_request(input req_type q);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      pending_rsps.push_back(anneal_predict(q));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_INIT_TEMP) start_temp = val[19:0];
      else if (idx == CSR_COOLING) cool_mult = val;
      else if (idx == CSR_STOP) stop_temp = val;
   endtask

   function automatic req_type noise_req(input kind_type k);
      req_type q;
      q = req_type'({$urandom, $urandom});
      q.kind = k;
      return q;
   endfunction

   task automatic send_load(input int idx, input int x, input int y);
      req_type q;
      q = noise_req(KIND_LOAD);
      q.city_index = 5'(idx);
      q.x_coord = 8'(x);
      q.y_coord = 8'(y);
      send_request(q);
   endtask

   task automatic send_swap(input int a, input int b, input int r);
      req_type q;
      q = noise_req(KIND_SWAP);
      q.swap_first = 5'(a);
      q.swap_second = 5'(b);
      q.random_draw = 16'(r);
      send_request(q);
   endtask

   task automatic send_read(input int idx);
      req_type q;
      q = noise_req(KIND_READ);
      q.city_index = 5'(idx);
      send_request(q);
   endtask

   // Response checker: each response against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $display("ERROR %0t: response with no request outstanding", $time);
            error_count++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.accepted !== want.accepted)
               report_mismatch("accepted", rsp_data.accepted, want.accepted);
            if (rsp_data.current_score !== want.current_score)
               report_mismatch("current_score", rsp_data.current_score, want.current_score);
            if (rsp_data.candidate_score !== want.candidate_score)
               report_mismatch("candidate_score", rsp_data.candidate_score,
                               want.candidate_score);
            if (rsp_data.finished !== want.finished)
               report_mismatch("finished", rsp_data.finished, want.finished);
            if (rsp_data.city_at_position !== want.city_at_position)
               report_mismatch("city_at_position", rsp_data.city_at_position,
                               want.city_at_position);
            if (rsp_data.bad_request !== want.bad_request)
               report_mismatch("bad_request", rsp_data.bad_request, want.bad_request);
         end
      end
   end

   // Receiver back-pressure.
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   // Every city is loaded first so that scoring never touches an unset entry,
   // then the corner cases are walked through under the default registers.
   task automatic test_directed();
      for (int i = 0; i < CITIES; i++)
         send_load(i, (i % 2) ? 255 : 0, (i % 3) ? 8'(i * 37) : 255);
      send_swap(0, 1, 100);
      send_load(20, 255, 255);
      send_load(31, 0, 0);
      send_read(31);
      send_request(noise_req(KIND_START));
      send_swap(3, 3, 1000);
      send_swap(31, 2, 1000);
      send_swap(1, 2, 0);
      send_swap(0, 19, 16'hFFFF);
      send_swap(5, 6, 1);
      send_load(4, 128, 128);
      send_read(19);
      send_read(0);
   endtask

   // Register extremes: a single cooling step ends the first run and the next swap is ignored.
   task automatic test_register_extremes();
      write_reg(CSR_INIT_TEMP, 32'd1);
      write_reg(CSR_COOLING, 32'd0);
      write_reg(CSR_STOP, 32'hFFFF_FFFF);
      send_request(noise_req(KIND_START));
      send_swap(2, 7, 40000);
      send_swap(2, 7, 40000);
      write_reg(CSR_INIT_TEMP, 32'hF_FFFF);
      write_reg(CSR_COOLING, 32'hFFFF_FFFF);
      write_reg(CSR_STOP, 32'd0);
      send_request(noise_req(KIND_START));
      for (int i = 0; i < 6; i++) send_swap(i, 19 - i, $urandom);
   endtask

   // Mostly legal swaps inside runs, with restarts, reads, reloads and malformed requests.
   task automatic test_random_anneal(input int count, input bit pause_midway);
      int      roll;
      int      a;
      req_type q;
      send_request(noise_req(KIND_START));
      for (int n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) wait_drained();
         roll = $urandom_range(99);
         if (run_over && roll < 50) roll = 0;
         if (roll < 8) begin
            send_request(noise_req(KIND_START));
         end else if (roll < 70) begin
            a = $urandom_range(CITIES - 1);
            send_swap(a, (a + $urandom_range(1, CITIES - 1)) % CITIES,
                      ($urandom_range(19) == 0) ? 0 : $urandom);
         end else if (roll < 78) begin
            send_read($urandom_range(CITIES - 1));
         end else if (roll < 84) begin
            send_load($urandom_range(CITIES - 1), $urandom, $urandom);
         end else begin
            q = noise_req(($urandom_range(1)) ? KIND_SWAP : (($urandom_range(1)) ?
                          KIND_LOAD : KIND_READ));
            if (q.kind == KIND_SWAP && $urandom_range(1)) q.swap_second = q.swap_first;
            else if (q.kind == KIND_SWAP) q.swap_first = 5'($urandom_range(CITIES, 31));
            else q.city_index = 5'($urandom_range(CITIES, 31));
            send_request(q);
         end
      end
   endtask

   initial begin
      error_count = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_INIT_TEMP;
      csr_wdata   = '0;
      fill_log_tab();
      for (int i = 0; i < CITIES; i++) tour_now[i] = 5'(i);
      score_held = '0;
      temp_held  = 0;
      run_over   = 1'b1;
      start_temp = 20'd1000000;
      cool_mult  = 32'd4294924346;
      stop_temp  = 32'd4294967;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_register_extremes();

      write_reg(CSR_INIT_TEMP, 32'd1000);
      write_reg(CSR_COOLING, 32'hE666_6666);
      write_reg(CSR_STOP, 32'd4294967);
      test_random_anneal(380, 1'b1);

      idle_pct = 76;
      write_reg(CSR_INIT_TEMP, 32'hF_FFFF);
      write_reg(CSR_COOLING, 32'hC000_0000);
      write_reg(CSR_STOP, 32'd0);
      test_random_anneal(380, 1'b0);

      idle_pct  = 0;
      stall_pct = 76;
      write_reg(CSR_INIT_TEMP, 32'd1);
      write_reg(CSR_COOLING, 32'hFFFF_FFFF);
      write_reg(CSR_STOP, 32'hFFFF_FFFF);
      test_random_anneal(380, 1'b0);

      idle_pct  = 21;
      stall_pct = 21;
      write_reg(CSR_INIT_TEMP, $urandom_range(1, 5000));
      write_reg(CSR_COOLING, $urandom_range(32'hF000_0000, 32'hFFF0_0000));
      write_reg(CSR_STOP, $urandom_range(32'd1, 32'hFFFF_FFFF));
      test_random_anneal(380, 1'b0);

      wait_drained();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
